/* rtl/brq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brq_pkg
// Shared types, codes and constants of the overwriting batch ring queue.
// ----------------------------------------------------------------------------
package brq_pkg;

  // Fixed field widths of the request and result channels.
  localparam int REQ_W      = 2;
  localparam int ENTRY_W    = 32;
  localparam int AMOUNT_W   = 6;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 9;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam int ACTIVE_W   = 4;
  localparam int BATCH_W    = 6;

  localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_BLOCKS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BATCH_SIZE    = 2'd1;

  // Default sizing.
  localparam int MAX_BLOCKS_DEF     = 8;
  localparam int BLOCK_CAPACITY_DEF = 32;
  localparam int ENTRY_BITS_DEF     = 32;

  // Most entries one peek may return.
  localparam int RES_MAX = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_PEEK   = 2'd1,
    REQ_DROP   = 2'd2,
    REQ_COUNT  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ARG = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [ENTRY_W-1:0]   data;
    logic [COUNT_W-1:0]   count;
    logic                 retired;
    logic                 last;
  } res_t;

endpackage
`default_nettype wire

/* rtl/brq_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brq_ifs
// Valid/ready channels for requests into and results out of the ring queue.
// ----------------------------------------------------------------------------
interface brq_in_if import brq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [ENTRY_W-1:0]  entry_data;
  logic                last_entry;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, req_type, entry_data, last_entry, amount, input ready);
  modport sink   (input valid, req_type, entry_data, last_entry, amount, output ready);
endinterface

interface brq_out_if import brq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ENTRY_W-1:0]  entry_data_out;
  logic [COUNT_W-1:0]  count_value;
  logic                oldest_retired;
  logic                last_result;

  modport source (output valid, status, entry_data_out, count_value, oldest_retired,
                  last_result, input ready);
  modport sink   (input valid, status, entry_data_out, count_value, oldest_retired,
                  last_result, output ready);
endinterface
`default_nettype wire

/* rtl/brq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brq_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/brq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brq_ctrl
// Request sequencer of the ring queue: staging, batch commit copy, peek reads
// and the ring bookkeeping. Owns the entry, staging and fill memories.
// ----------------------------------------------------------------------------
module brq_ctrl import brq_pkg::*; #(
  parameter  int MAX_BLOCKS     = MAX_BLOCKS_DEF,
  parameter  int BLOCK_CAPACITY = BLOCK_CAPACITY_DEF,
  parameter  int ENTRY_BITS     = ENTRY_BITS_DEF,
  localparam int UW             = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  brq_in_if.sink                  in_chan,
  input  wire logic [UW-1:0]      eff_blocks,
  input  wire logic [BATCH_W-1:0] batch_size,
  input  wire logic               cfg_clear,
  input  wire logic               out_free,
  output      logic               ld_valid,
  output      res_t               ld_res
);

  localparam int SW   = $clog2(MAX_BLOCKS);
  localparam int FW   = $clog2(BLOCK_CAPACITY + 1);
  localparam int OW   = (BLOCK_CAPACITY > 1) ? $clog2(BLOCK_CAPACITY) : 1;
  localparam int CW   = $clog2(BLOCK_CAPACITY + 2);
  localparam int EAW  = $clog2(MAX_BLOCKS * BLOCK_CAPACITY);
  localparam int PW   = $clog2(MAX_BLOCKS * BLOCK_CAPACITY + 1);
  localparam int DW   = (ENTRY_BITS < ENTRY_W) ? ENTRY_BITS : ENTRY_W;
  localparam int CMPW = (CW > BATCH_W) ? CW : BATCH_W;
  localparam int AW2  = (FW > AMOUNT_W) ? FW : AMOUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_PEEK_RD,
    S_PEEK_OUT,
    S_RESP
  } state_t;

  function automatic logic [SW-1:0] adv(input logic [SW-1:0] slot,
                                        input logic [UW-1:0] eff);
    logic [UW-1:0] inc;
    begin
      inc = UW'(slot) + UW'(1);
      adv = (inc >= eff) ? '0 : SW'(inc);
    end
  endfunction

  // Control state.
  state_t         state_r, state_nxt;
  logic [SW-1:0]  oldest_r, oldest_nxt;
  logic [SW-1:0]  next_r, next_nxt;
  logic [UW-1:0]  used_r, used_nxt;
  logic [PW-1:0]  pend_r, pend_nxt;
  logic [OW-1:0]  roff_r, roff_nxt;
  logic [CW-1:0]  stg_cnt_r, stg_cnt_nxt;
  logic           fetch_r, fetch_nxt;
  logic [CW-1:0]  cp_rd_r, cp_rd_nxt;
  logic           cp_wr_r, cp_wr_nxt;

  // Payload state.
  logic [FW-1:0]       ofill_r, ofill_nxt;
  logic [CW-1:0]       cp_n_r, cp_n_nxt;
  logic [EAW-1:0]      cp_base_r, cp_base_nxt;
  logic [OW-1:0]       cp_widx_r, cp_widx_nxt;
  logic [EAW-1:0]      pk_addr_r, pk_addr_nxt;
  logic [AMOUNT_W-1:0] pk_left_r, pk_left_nxt;
  logic [AMOUNT_W-1:0] pk_k_r, pk_k_nxt;
  res_t                resp_r, resp_nxt;

  // Memory ports.
  logic           stg_we, stg_re;
  logic [DW-1:0]  stg_rdata;
  logic           ent_we, ent_re;
  logic [DW-1:0]  ent_rdata;
  logic           fill_we, fill_re;
  logic [FW-1:0]  fill_rdata;

  // Derived values.
  logic                accept;
  req_t                req;
  logic [FW-1:0]       remaining;
  logic                full;
  logic [UW-1:0]       used_m1;
  logic [SW-1:0]       oldest_adv;
  logic [SW-1:0]       ret_oldest;
  logic                ret_fetch;
  logic                stg_add;
  logic [CW-1:0]       n_new;
  logic                batch_ok;
  logic                batch_bad;
  logic [PW-1:0]       disc_p;
  logic [PW-1:0]       pend_disc;
  logic [UW-1:0]       used_pre;
  logic [SW-1:0]       oldest_pre;
  logic [AW2-1:0]      amt_w;
  logic [AW2-1:0]      rem_w;
  logic [AW2-1:0]      pk_min;
  logic [AMOUNT_W-1:0] pk_k;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign req           = req_t'(in_chan.req_type);

  assign remaining  = ofill_r - FW'(roff_r);
  assign full       = (used_r >= eff_blocks);
  assign used_m1    = used_r - UW'(1);
  assign oldest_adv = adv(oldest_r, eff_blocks);
  assign ret_oldest = (used_m1 == '0) ? next_r : oldest_adv;
  assign ret_fetch  = (used_m1 != '0);

  assign stg_add    = (stg_cnt_r < CW'(BLOCK_CAPACITY));
  assign n_new      = stg_add ? (stg_cnt_r + CW'(1)) : CW'(BLOCK_CAPACITY + 1);
  assign batch_ok   = (batch_size == '0) || (CMPW'(n_new) == CMPW'(batch_size));
  assign batch_bad  = (n_new == '0) || (n_new > CW'(BLOCK_CAPACITY)) || !batch_ok;
  assign disc_p     = PW'(remaining);
  assign pend_disc  = !full ? pend_r : ((pend_r < disc_p) ? '0 : (pend_r - disc_p));
  assign used_pre   = full ? used_m1 : used_r;
  assign oldest_pre = full ? ret_oldest : oldest_r;

  assign amt_w  = AW2'(in_chan.amount);
  assign rem_w  = AW2'(remaining);
  assign pk_min = (amt_w < rem_w) ? amt_w : rem_w;
  assign pk_k   = (pk_min > AW2'(RES_MAX)) ? AMOUNT_W'(RES_MAX) : AMOUNT_W'(pk_min);

  always_comb begin
    state_nxt   = state_r;
    oldest_nxt  = oldest_r;
    next_nxt    = next_r;
    used_nxt    = used_r;
    pend_nxt    = pend_r;
    roff_nxt    = roff_r;
    stg_cnt_nxt = stg_cnt_r;
    fetch_nxt   = 1'b0;
    cp_rd_nxt   = cp_rd_r;
    cp_wr_nxt   = cp_wr_r;
    ofill_nxt   = fetch_r ? fill_rdata : ofill_r;
    cp_n_nxt    = cp_n_r;
    cp_base_nxt = cp_base_r;
    cp_widx_nxt = cp_widx_r;
    pk_addr_nxt = pk_addr_r;
    pk_left_nxt = pk_left_r;
    pk_k_nxt    = pk_k_r;
    resp_nxt    = resp_r;
    stg_we      = 1'b0;
    stg_re      = 1'b0;
    ent_we      = 1'b0;
    ent_re      = 1'b0;
    fill_we     = 1'b0;
    fill_re     = 1'b0;
    ld_valid    = 1'b0;
    ld_res      = resp_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          resp_nxt = '{status: ST_OK, data: '0, count: '0, retired: 1'b0, last: 1'b1};
          unique case (req)
            REQ_APPEND: begin
              stg_we      = stg_add;
              stg_cnt_nxt = n_new;
              if (in_chan.last_entry) begin
                stg_cnt_nxt = '0;
                if (batch_bad) begin
                  resp_nxt.status = ST_BAD_ARG;
                  state_nxt       = S_RESP;
                end else begin
                  // Ring full: the oldest block goes first, then the batch
                  // lands in the next slot.
                  fill_we = 1'b1;
                  if (used_pre == '0) begin
                    oldest_nxt = next_r;
                    roff_nxt   = '0;
                    ofill_nxt  = FW'(n_new);
                  end else begin
                    oldest_nxt = oldest_pre;
                    if (full) begin
                      roff_nxt  = '0;
                      fill_re   = 1'b1;
                      fetch_nxt = 1'b1;
                    end
                  end
                  next_nxt    = adv(next_r, eff_blocks);
                  used_nxt    = used_pre + UW'(1);
                  pend_nxt    = pend_disc + PW'(n_new);
                  cp_rd_nxt   = '0;
                  cp_wr_nxt   = 1'b0;
                  cp_n_nxt    = n_new;
                  cp_base_nxt = EAW'(int'(next_r) * BLOCK_CAPACITY);
                  state_nxt   = S_COPY;
                end
              end
            end
            REQ_PEEK: begin
              if ((in_chan.amount == '0) || (used_r == '0) || (pk_k == '0)) begin
                state_nxt = S_RESP;
              end else begin
                pk_addr_nxt = EAW'(int'(oldest_r) * BLOCK_CAPACITY) + EAW'(roff_r);
                pk_left_nxt = pk_k;
                pk_k_nxt    = pk_k;
                state_nxt   = S_PEEK_RD;
              end
            end
            REQ_DROP: begin
              state_nxt = S_RESP;
              if (in_chan.amount == '0) begin
                resp_nxt.status = ST_OK;
              end else if (used_r == '0) begin
                resp_nxt.status = ST_EMPTY;
              end else if (amt_w > rem_w) begin
                resp_nxt.status = ST_BAD_ARG;
              end else begin
                pend_nxt = pend_r - PW'(in_chan.amount);
                if (amt_w == rem_w) begin
                  oldest_nxt       = ret_oldest;
                  used_nxt         = used_m1;
                  roff_nxt         = '0;
                  fill_re          = ret_fetch;
                  fetch_nxt        = ret_fetch;
                  resp_nxt.retired = 1'b1;
                end else begin
                  roff_nxt = roff_r + OW'(in_chan.amount);
                end
              end
            end
            REQ_COUNT: begin
              resp_nxt.count = COUNT_W'(pend_r);
              state_nxt      = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_COPY: begin
        // Staging read data is written to the entry store in the cycle after the read.
        stg_re      = (cp_rd_r < cp_n_r);
        cp_rd_nxt   = stg_re ? (cp_rd_r + CW'(1)) : cp_rd_r;
        cp_wr_nxt   = stg_re;
        cp_widx_nxt = cp_rd_r[OW-1:0];
        ent_we      = cp_wr_r;
        if (cp_wr_r && (cp_rd_r == cp_n_r)) begin
          state_nxt = S_RESP;
        end
      end

      S_PEEK_RD: begin
        ent_re      = 1'b1;
        pk_addr_nxt = pk_addr_r + EAW'(1);
        pk_left_nxt = pk_left_r - AMOUNT_W'(1);
        state_nxt   = S_PEEK_OUT;
      end

      S_PEEK_OUT: begin
        if (out_free) begin
          ld_valid = 1'b1;
          ld_res   = '{status: ST_OK, data: ENTRY_W'(ent_rdata), count: COUNT_W'(pk_k_r),
                       retired: 1'b0, last: (pk_left_r == '0)};
          state_nxt = (pk_left_r == '0) ? S_IDLE : S_PEEK_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          ld_valid  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Rewriting the active slot count empties the ring; staging is kept.
    if (cfg_clear) begin
      oldest_nxt = '0;
      next_nxt   = '0;
      used_nxt   = '0;
      pend_nxt   = '0;
      roff_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      oldest_r  <= '0;
      next_r    <= '0;
      used_r    <= '0;
      pend_r    <= '0;
      roff_r    <= '0;
      stg_cnt_r <= '0;
      fetch_r   <= 1'b0;
      cp_rd_r   <= '0;
      cp_wr_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      oldest_r  <= oldest_nxt;
      next_r    <= next_nxt;
      used_r    <= used_nxt;
      pend_r    <= pend_nxt;
      roff_r    <= roff_nxt;
      stg_cnt_r <= stg_cnt_nxt;
      fetch_r   <= fetch_nxt;
      cp_rd_r   <= cp_rd_nxt;
      cp_wr_r   <= cp_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ofill_r   <= ofill_nxt;
    cp_n_r    <= cp_n_nxt;
    cp_base_r <= cp_base_nxt;
    cp_widx_r <= cp_widx_nxt;
    pk_addr_r <= pk_addr_nxt;
    pk_left_r <= pk_left_nxt;
    pk_k_r    <= pk_k_nxt;
    resp_r    <= resp_nxt;
  end

  brq_ram #(
    .WIDTH (DW),
    .DEPTH (BLOCK_CAPACITY)
  ) u_stg_ram (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_cnt_r[OW-1:0]),
    .wdata (in_chan.entry_data[DW-1:0]),
    .re    (stg_re),
    .raddr (cp_rd_r[OW-1:0]),
    .rdata (stg_rdata)
  );

  brq_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_BLOCKS * BLOCK_CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (cp_base_r + EAW'(cp_widx_r)),
    .wdata (stg_rdata),
    .re    (ent_re),
    .raddr (pk_addr_r),
    .rdata (ent_rdata)
  );

  brq_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_BLOCKS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (next_r),
    .wdata (FW'(n_new)),
    .re    (fill_re),
    .raddr (oldest_adv),
    .rdata (fill_rdata)
  );

endmodule
`default_nettype wire

/* rtl/brq_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brq_out_stage
// Result output register that decouples the sequencer from the result sink.
// ----------------------------------------------------------------------------
module brq_out_stage import brq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic ld_valid,
  input  wire res_t ld_res,
  output      logic ld_free,
  brq_out_if.source out_chan
);

  logic valid_r;
  res_t res_r;

  assign ld_free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld_valid) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid) begin
      res_r <= ld_res;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.status         = res_r.status;
  assign out_chan.entry_data_out = res_r.data;
  assign out_chan.count_value    = res_r.count;
  assign out_chan.oldest_retired = res_r.retired;
  assign out_chan.last_result    = res_r.last;

endmodule
`default_nettype wire

/* rtl/batch_ring_queue_overwrite.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// batch_ring_queue_overwrite
// Overwriting ring queue of entry batches with peek, drop and count requests.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A non-final append entry leaves the
// block idle, so the next request can follow right away. A final append entry
// checks the batch and, when it is accepted, copies the n staged entries into
// the entry store through the staging memory's one read port before its single
// result is presented. Peek reads the entry store one entry per request to its
// read port and presents each entry's result before it reads the next one;
// drop, count and rejected batches present their result from a response state
// once the output register is free. Results sit in an output register, so a
// stalled result sink holds back only the next result, not the acceptance of
// a new request in the idle state. When the ring is full, a committed batch
// replaces the oldest block and its unread entries. Writing the active slot
// count empties the ring but keeps a half-staged batch. Configuration should
// be written only while no request is in progress. The memories need no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module batch_ring_queue_overwrite import brq_pkg::*; #(
  parameter int MAX_BLOCKS     = MAX_BLOCKS_DEF,
  parameter int BLOCK_CAPACITY = BLOCK_CAPACITY_DEF,
  parameter int ENTRY_BITS     = ENTRY_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  brq_in_if.sink                     in_chan,
  brq_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int UW  = $clog2(MAX_BLOCKS + 1);
  localparam int CLW = (UW > ACTIVE_W) ? UW : ACTIVE_W;

  // The active slot count is held already clamped to one..MAX_BLOCKS.
  logic [UW-1:0]       eff_r, eff_nxt;
  logic [BATCH_W-1:0]  batch_r, batch_nxt;
  logic [ACTIVE_W-1:0] act_val;
  logic [UW-1:0]       act_clamped;
  logic                cfg_clear;
  logic                out_free;
  logic                ld_valid;
  res_t                ld_res;

  assign act_val   = cfg_wdata[ACTIVE_W-1:0];
  assign cfg_clear = cfg_we && (cfg_addr == CFG_ACTIVE_BLOCKS);

  always_comb begin
    if (act_val == '0) begin
      act_clamped = UW'(1);
    end else if (CLW'(act_val) > CLW'(MAX_BLOCKS)) begin
      act_clamped = UW'(MAX_BLOCKS);
    end else begin
      act_clamped = UW'(act_val);
    end
  end

  always_comb begin
    eff_nxt   = eff_r;
    batch_nxt = batch_r;
    if (cfg_we) begin
      if (cfg_addr == CFG_ACTIVE_BLOCKS) begin
        eff_nxt = act_clamped;
      end else if (cfg_addr == CFG_BATCH_SIZE) begin
        batch_nxt = cfg_wdata[BATCH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r   <= UW'(MAX_BLOCKS);
      batch_r <= '0;
    end else begin
      eff_r   <= eff_nxt;
      batch_r <= batch_nxt;
    end
  end

  brq_ctrl #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .BLOCK_CAPACITY (BLOCK_CAPACITY),
    .ENTRY_BITS     (ENTRY_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .eff_blocks (eff_r),
    .batch_size (batch_r),
    .cfg_clear  (cfg_clear),
    .out_free   (out_free),
    .ld_valid   (ld_valid),
    .ld_res     (ld_res)
  );

  brq_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (ld_valid),
    .ld_res   (ld_res),
    .ld_free  (out_free),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

/* test/brq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brq_checker
// Watches the request, result and register ports of the batch ring queue.
// It keeps its own copy of the ring, works out the results of every accepted
// request and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module brq_checker import brq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  brq_in_if                          in_mon,
  brq_out_if                         out_mon,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int SLOTS = MAX_BLOCKS_DEF;
  localparam int CAP   = BLOCK_CAPACITY_DEF;

  logic [ENTRY_W-1:0]  stored [SLOTS*CAP];
  logic [5:0]          slot_fill [SLOTS];
  logic [ENTRY_W-1:0]  staged [CAP];
  logic [5:0]          staged_cnt;
  logic [2:0]          head_slot;
  logic [2:0]          tail_slot;
  logic [3:0]          slots_used;
  logic [COUNT_W-1:0]  entries_pending;
  logic [4:0]          head_offset;
  logic [ACTIVE_W-1:0] active_reg;
  logic [BATCH_W-1:0]  batch_reg;
  res_t                awaited_results [$];
  int                  errors = 0;

  assign mismatches = errors;

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] checker: %s", $time, what);
  endtask

  // A slot count of zero behaves as one, anything above the ring size as the ring size.
  function automatic int slot_limit();
    if (active_reg == 0) return 1;
    if (active_reg > SLOTS) return SLOTS;
    return active_reg;
  endfunction

  function automatic logic [2:0] slot_after(logic [2:0] s);
    return (int'(s) + 1 >= slot_limit()) ? 3'd0 : s + 3'd1;
  endfunction

  function automatic void empty_ring();
    head_slot       = '0;
    tail_slot       = '0;
    slots_used      = '0;
    entries_pending = '0;
    head_offset     = '0;
  endfunction

  function automatic void retire_head();
    head_slot   = slot_after(head_slot);
    slots_used  = slots_used - 4'd1;
    head_offset = '0;
    if (slots_used == 0) head_slot = tail_slot;
  endfunction

  function automatic void await_result(status_t st, logic [ENTRY_W-1:0] d,
                                       logic [COUNT_W-1:0] c, logic ret, logic fin);
    res_t r;
    r.status  = st;
    r.data    = d;
    r.count   = c;
    r.retired = ret;
    r.last    = fin;
    awaited_results.push_back(r);
  endfunction

  // Works out the results of one accepted request and updates the ring.
  function automatic void ring_request(req_t kind, logic [ENTRY_W-1:0] data,
                                       logic fin, logic [AMOUNT_W-1:0] amt);
    int n;
    int avail;
    int k;
    int disc;
    case (kind)
      REQ_APPEND: begin
        if (staged_cnt < CAP) begin
          staged[staged_cnt[4:0]] = data;
          staged_cnt = staged_cnt + 6'd1;
        end else begin
          staged_cnt = 6'(CAP + 1);
        end
        if (!fin) return;
        n = int'(staged_cnt);
        staged_cnt = '0;
        if (n == 0 || n > CAP || (batch_reg != 0 && n != batch_reg)) begin
          await_result(ST_BAD_ARG, '0, '0, 1'b0, 1'b1);
          return;
        end
        // A full ring loses its oldest block, unread entries included.
        if (slots_used >= slot_limit()) begin
          disc = int'(slot_fill[head_slot]) - int'(head_offset);
          entries_pending = (entries_pending < disc) ? '0 :
                            COUNT_W'(int'(entries_pending) - disc);
          retire_head();
        end
        for (int i = 0; i < n; i++) stored[tail_slot*CAP + i] = staged[i];
        slot_fill[tail_slot] = 6'(n);
        if (slots_used == 0) begin
          head_slot   = tail_slot;
          head_offset = '0;
        end
        tail_slot       = slot_after(tail_slot);
        slots_used      = slots_used + 4'd1;
        entries_pending = COUNT_W'(int'(entries_pending) + n);
        await_result(ST_OK, '0, '0, 1'b0, 1'b1);
      end
      REQ_PEEK: begin
        if (amt == 0 || slots_used == 0) begin
          await_result(ST_OK, '0, '0, 1'b0, 1'b1);
          return;
        end
        avail = int'(slot_fill[head_slot]) - int'(head_offset);
        k = (amt < avail) ? int'(amt) : avail;
        if (k > RES_MAX) k = RES_MAX;
        if (k == 0) begin
          await_result(ST_OK, '0, '0, 1'b0, 1'b1);
          return;
        end
        for (int i = 0; i < k; i++)
          await_result(ST_OK, stored[head_slot*CAP + head_offset + i], COUNT_W'(k), 1'b0,
                       i == k - 1);
      end
      REQ_DROP: begin
        if (amt == 0) begin
          await_result(ST_OK, '0, '0, 1'b0, 1'b1);
          return;
        end
        if (slots_used == 0) begin
          await_result(ST_EMPTY, '0, '0, 1'b0, 1'b1);
          return;
        end
        avail = int'(slot_fill[head_slot]) - int'(head_offset);
        if (amt > avail) begin
          await_result(ST_BAD_ARG, '0, '0, 1'b0, 1'b1);
          return;
        end
        entries_pending = entries_pending - COUNT_W'(amt);
        if (amt == avail) begin
          retire_head();
          await_result(ST_OK, '0, '0, 1'b1, 1'b1);
        end else begin
          head_offset = 5'(head_offset + amt);
          await_result(ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      default: begin
        await_result(ST_OK, '0, entries_pending, 1'b0, 1'b1);
      end
    endcase
  endfunction

  task automatic field_check(string name, logic [ENTRY_W-1:0] got, logic [ENTRY_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result();
    res_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing outstanding, status %0d data %0h",
                                out_mon.status, out_mon.entry_data_out));
      return;
    end
    want = awaited_results.pop_front();
    field_check("status", ENTRY_W'(out_mon.status), ENTRY_W'(want.status));
    field_check("entry_data_out", out_mon.entry_data_out, want.data);
    field_check("count_value", ENTRY_W'(out_mon.count_value), ENTRY_W'(want.count));
    field_check("oldest_retired", ENTRY_W'(out_mon.oldest_retired), ENTRY_W'(want.retired));
    field_check("last_result", ENTRY_W'(out_mon.last_result), ENTRY_W'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_ring();
      staged_cnt = '0;
      active_reg = ACTIVE_W'(MAX_BLOCKS_DEF);
      batch_reg  = '0;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_we) begin
        if (cfg_addr == CFG_ACTIVE_BLOCKS) begin
          active_reg = cfg_wdata[ACTIVE_W-1:0];
          empty_ring();
        end else if (cfg_addr == CFG_BATCH_SIZE) begin
          batch_reg = cfg_wdata[BATCH_W-1:0];
        end
      end
      if (in_mon.valid && in_mon.ready)
        ring_request(req_t'(in_mon.req_type), in_mon.entry_data, in_mon.last_entry,
                     in_mon.amount);
    end
    outstanding <= awaited_results.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the overwriting batch ring queue. A directed run
// covers empty-ring requests, bad arguments, block retirement, slot-count
// clamping, overwrite of a full ring and rejected batches. Random phases then
// mix append batches, peeks, drops and counts under several register settings
// and request/result throttling patterns, while brq_checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench import brq_pkg::*; ();

  // Register indexes past the end of the map; writes to them must be ignored.
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_B = 2'd3;

  localparam int CAP = BLOCK_CAPACITY_DEF;

  // Quiet cycles after the last result before touching registers or ending.
  // A non-final append has no result and leaves the block idle, so a few suffice.
  localparam int SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    fail_total;
  int                    in_flight;
  int                    items_sent;

  brq_in_if  in_if ();
  brq_out_if out_if ();

  batch_ring_queue_overwrite dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  brq_checker monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (fail_total),
    .outstanding(in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. The slowest legal run (every request a 32-entry peek, each
  // result held back by a long receiver stall) stays well below this.
  initial begin
    #20_000_000;
    $display("batch_ring_queue_overwrite: mismatch");
    $finish;
  end

  // The result side stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one request, optionally after a random idle gap, and returns on
  // the edge that accepts it. Valid is left high so that a back-to-back
  // request never lowers and raises it within one time step.
  task automatic issue(req_t kind, logic [ENTRY_W-1:0] data, logic fin,
                       logic [AMOUNT_W-1:0] amt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.req_type   <= kind;
    in_if.entry_data <= data;
    in_if.last_entry <= fin;
    in_if.amount     <= amt;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops sending and waits until every predicted result has been delivered,
  // then lets the block go quiet.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers are only written while the block is idle, so callers settle first.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase. Most traffic is well-formed: batches that match the
  // configured size, peeks and drops of a few entries. A share is noise:
  // oversized batches, odd batch lengths and large amounts.
  task automatic run_phase(logic [CFG_DATA_W-1:0] slots_word, logic [BATCH_W-1:0] bsize,
                           int idle, int stall, int target);
    int pick;
    int len;
    settle();
    write_reg(CFG_ACTIVE_BLOCKS, slots_word);
    write_reg(CFG_BATCH_SIZE, bsize);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    items_sent     = 0;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(19) == 0) len = CAP + 1 + $urandom_range(2);
        else if (bsize != 0 && bsize <= CAP && $urandom_range(7) != 0) len = bsize;
        else len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          issue(REQ_APPEND, $urandom, i == len - 1, AMOUNT_W'($urandom_range(63)));
      end else if (pick < 65) begin
        issue(REQ_PEEK, $urandom, 1'($urandom_range(1)),
              AMOUNT_W'(($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(1, 8)));
      end else if (pick < 87) begin
        issue(REQ_DROP, $urandom, 1'($urandom_range(1)),
              AMOUNT_W'(($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(1, 4)));
      end else begin
        issue(REQ_COUNT, $urandom, 1'($urandom_range(1)), AMOUNT_W'($urandom_range(63)));
      end
      // Now and then the sender holds off until the ring has answered everything.
      if ($urandom_range(24) == 0) settle();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = CFG_ACTIVE_BLOCKS;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.req_type   = REQ_COUNT;
    in_if.entry_data = '0;
    in_if.last_entry = 1'b0;
    in_if.amount     = '0;
    out_if.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    items_sent       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at reset settings (eight slots, any batch length).
    // Requests against an empty ring: count, peek, zero drop, drop on empty.
    issue(REQ_COUNT, 32'h0, 1'b0, 6'd0);
    issue(REQ_PEEK, 32'h0, 1'b1, 6'd5);
    issue(REQ_DROP, 32'h0, 1'b0, 6'd0);
    issue(REQ_DROP, 32'hFFFF_FFFF, 1'b1, 6'd3);
    // A one-entry batch with all bits set, then a two-entry batch.
    issue(REQ_APPEND, 32'hFFFF_FFFF, 1'b1, 6'd63);
    issue(REQ_APPEND, 32'h0000_0000, 1'b0, 6'd0);
    issue(REQ_APPEND, 32'hA5A5_5A5A, 1'b1, 6'd0);
    // Zero-length peek, then a peek asking for more than the block holds.
    issue(REQ_PEEK, 32'h0, 1'b0, 6'd0);
    issue(REQ_PEEK, 32'h0, 1'b0, 6'd63);
    // Drop past the unread entries is refused; an exact drop retires the block.
    issue(REQ_DROP, 32'h0, 1'b0, 6'd2);
    issue(REQ_DROP, 32'h0, 1'b0, 6'd1);
    issue(REQ_PEEK, 32'h0, 1'b0, 6'd1);
    // A partial drop only moves the read position.
    issue(REQ_DROP, 32'h0, 1'b0, 6'd1);
    issue(REQ_COUNT, 32'h0, 1'b0, 6'd0);
    // Stage one entry, then shrink the ring to a single slot (zero acts as
    // one). The ring empties but the staged entry must survive.
    issue(REQ_APPEND, 32'h1234_5678, 1'b0, 6'd0);
    settle();
    write_reg(CFG_ACTIVE_BLOCKS, 6'd0);
    issue(REQ_APPEND, 32'h8765_4321, 1'b1, 6'd0);
    // With one slot in use, the next batch overwrites the unread one.
    issue(REQ_APPEND, 32'h0000_0001, 1'b1, 6'd0);
    issue(REQ_PEEK, 32'h0, 1'b0, 6'd32);
    issue(REQ_COUNT, 32'h0, 1'b0, 6'd0);
    // Largest batch size rejects every batch; unmapped indexes change nothing.
    settle();
    write_reg(CFG_BATCH_SIZE, 6'd63);
    write_reg(CFG_UNMAPPED_A, 6'h3F);
    write_reg(CFG_UNMAPPED_B, 6'h15);
    issue(REQ_APPEND, 32'h5555_AAAA, 1'b1, 6'd0);
    // A batch of the wrong length is refused, the right length is taken.
    settle();
    write_reg(CFG_BATCH_SIZE, 6'd2);
    issue(REQ_APPEND, 32'hDEAD_BEEF, 1'b1, 6'd0);
    issue(REQ_APPEND, 32'h0F0F_0F0F, 1'b0, 6'd0);
    issue(REQ_APPEND, 32'hF0F0_F0F0, 1'b1, 6'd0);
    issue(REQ_DROP, 32'h0, 1'b0, 6'd63);

    // Random phases: single slot with no throttling, three slots and a fixed
    // batch under a mostly idle sender, a clamped slot count under a mostly
    // stalled receiver, and full batches with light throttling on both sides.
    run_phase(6'd1, 6'd0, 0, 0, 18);
    run_phase(6'd3, 6'd3, 88, 0, 18);
    run_phase(6'h3F, 6'd0, 0, 88, 18);
    run_phase(6'd8, 6'd32, 8, 8, 18);

    settle();
    if (fail_total == 0) begin
      $display("batch_ring_queue_overwrite: match");
    end else begin
      $display("batch_ring_queue_overwrite: mismatch");
    end
    $finish;
  end

endmodule
